FILE: hdl/utf8_char_ngram_extractor_top_defines.svh
// ----------------------------------------------------------------------------
// UTF-8 character n-gram extractor: assertion macros
// Concurrent assertion helpers shared by the extractor's modules. They are
// empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef UTF8_CHAR_NGRAM_EXTRACTOR_TOP_DEFINES_SVH
`define UTF8_CHAR_NGRAM_EXTRACTOR_TOP_DEFINES_SVH
`ifndef SYNTHESIS
// The property must hold at every rising clock edge outside reset.
`define UCNG_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("%m: assertion failed");
// The condition must never be true at a rising clock edge outside reset.
`define UCNG_NEVER(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("%m: forbidden condition seen");
`else
`define UCNG_ASSERT(lbl, clk, rst, prop)
`define UCNG_NEVER(lbl, clk, rst, cond)
`endif
`endif

FILE: hdl/ucng_pkg.sv
// ----------------------------------------------------------------------------
// UTF-8 character n-gram extractor package
// Constants, codes and the command and status bundles shared by the
// controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package ucng_pkg;

   localparam int MAX_GRAM_CHARS = 8;
   localparam int SLOT_BYTES     = 4;
   localparam int BYTE_W         = 8;
   localparam int GSIZE_W        = 4;
   localparam int LEN_W          = 3;
   localparam int BIDX_W         = 2;
   localparam int CSR_IDX_W      = 2;
   localparam int CSR_DATA_W     = 4;
   localparam int CIDX_W         = (MAX_GRAM_CHARS > 1) ? $clog2(MAX_GRAM_CHARS) : 1;
   localparam int FILL_W         = $clog2(MAX_GRAM_CHARS + 1);

   localparam logic [BYTE_W-1:0]  MARK_BYTE     = 8'h5F;
   localparam logic [GSIZE_W-1:0] GRAM_SIZE_RST = 4'd3;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PREFIX,
      ST_GRAM,
      ST_SUFFIX,
      ST_STATUS
   } ucng_state_type;

   typedef enum logic [1:0] {
      SRC_MARK,
      SRC_WINDOW,
      SRC_STATUS
   } ucng_src_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_GRAM_SIZE,
      CSR_ADD_PREFIX,
      CSR_ADD_SUFFIX
   } ucng_csr_type;

   // Controller to datapath.
   typedef struct packed {
      logic         take;
      logic         clear;
      logic         emit;
      ucng_src_type src;
      logic         gram_end;
      logic         last;
   } ucng_cmd_type;

   // Datapath to controller.
   typedef struct packed {
      logic gram_go;
      logic prefix_go;
      logic status_go;
      logic eos_now;
      logic suffix;
      logic status;
      logic byte_last;
      logic char_last;
      logic out_free;
   } ucng_stat_type;

endpackage

`default_nettype wire

FILE: hdl/ucng_if.sv
// ----------------------------------------------------------------------------
// UTF-8 character n-gram extractor channels
// Valid/ready channel bundles for the byte input and the result output.
// ----------------------------------------------------------------------------
`default_nettype none

interface ucng_req_if;
   logic                         valid;
   logic                         ready;
   logic [ucng_pkg::BYTE_W-1:0]  in_byte;
   logic                         end_of_string;

   modport source (output valid, output in_byte, output end_of_string, input ready);
   modport sink   (input valid, input in_byte, input end_of_string, output ready);
endinterface

interface ucng_rsp_if;
   logic                         valid;
   logic                         ready;
   logic                         kind;
   logic [ucng_pkg::BYTE_W-1:0]  out_byte;
   logic                         gram_end;
   logic                         any_grams;
   logic                         last;

   modport source (output valid, output kind, output out_byte, output gram_end,
                   output any_grams, output last, input ready);
   modport sink   (input valid, input kind, input out_byte, input gram_end,
                   input any_grams, input last, output ready);
endinterface

`default_nettype wire

FILE: hdl/ucng_ctrl.sv
// ----------------------------------------------------------------------------
// UTF-8 character n-gram extractor controller
// Sequences acceptance of one byte and the emission of its gram and status
// items.
// ----------------------------------------------------------------------------
`default_nettype none
`include "utf8_char_ngram_extractor_top_defines.svh"

module ucng_ctrl (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     req_valid,
   output logic                    req_ready,
   input  ucng_pkg::ucng_stat_type stat,
   output ucng_pkg::ucng_cmd_type  cmd
);
   import ucng_pkg::*;

   ucng_state_type state_ff;
   ucng_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      cmd.src      = SRC_MARK;
      req_ready    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.take = 1'b1;
               if (stat.gram_go) begin
                  state_in = stat.prefix_go ? ST_PREFIX : ST_GRAM;
               end else if (stat.status_go) begin
                  state_in = ST_STATUS;
               end else begin
                  cmd.clear = stat.eos_now;
               end
            end
         end
         ST_PREFIX: begin
            if (stat.out_free) begin
               cmd.emit = 1'b1;
               cmd.src  = SRC_MARK;
               state_in = ST_GRAM;
            end
         end
         ST_GRAM: begin
            if (stat.out_free) begin
               cmd.emit = 1'b1;
               cmd.src  = SRC_WINDOW;
               if (stat.byte_last && stat.char_last) begin
                  cmd.gram_end = !stat.suffix;
                  cmd.last     = !stat.suffix && !stat.status;
                  if (stat.suffix) begin
                     state_in = ST_SUFFIX;
                  end else if (stat.status) begin
                     state_in = ST_STATUS;
                  end else begin
                     state_in = ST_IDLE;
                  end
               end
            end
         end
         ST_SUFFIX: begin
            if (stat.out_free) begin
               cmd.emit     = 1'b1;
               cmd.src      = SRC_MARK;
               cmd.gram_end = 1'b1;
               cmd.last     = !stat.status;
               state_in     = stat.status ? ST_STATUS : ST_IDLE;
            end
         end
         ST_STATUS: begin
            if (stat.out_free) begin
               cmd.emit  = 1'b1;
               cmd.src   = SRC_STATUS;
               cmd.last  = 1'b1;
               cmd.clear = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   `UCNG_NEVER(a_emit_needs_room, clock, reset, cmd.emit && !stat.out_free)
   `UCNG_NEVER(a_clear_place, clock, reset, cmd.clear && (state_ff != ST_IDLE) && (state_ff != ST_STATUS))
   `UCNG_ASSERT(a_status_ends, clock, reset, (cmd.emit && (state_ff == ST_STATUS)) |=> (state_ff == ST_IDLE))

endmodule

`default_nettype wire

FILE: hdl/ucng_dp.sv
// ----------------------------------------------------------------------------
// UTF-8 character n-gram extractor datapath
// Configuration registers, UTF-8 decoder, character window, gram read-out
// counters and the result output register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "utf8_char_ngram_extractor_top_defines.svh"

module ucng_dp (
   input  wire                                   clock,
   input  wire                                   reset,
   input  wire  [ucng_pkg::BYTE_W-1:0]           in_byte,
   input  wire                                   end_of_string,
   input  wire                                   csr_we,
   input  wire  [ucng_pkg::CSR_IDX_W-1:0]        csr_index,
   input  wire  [ucng_pkg::CSR_DATA_W-1:0]       csr_wdata,
   input  ucng_pkg::ucng_cmd_type                cmd,
   output ucng_pkg::ucng_stat_type               stat,
   ucng_rsp_if.source                            rsp
);
   import ucng_pkg::*;

   typedef logic [BYTE_W-1:0] slot_type [SLOT_BYTES];

   // Configuration.
   logic [GSIZE_W-1:0] gsize_ff, gsize_in;
   logic               pfx_cfg_ff, pfx_cfg_in;
   logic               sfx_cfg_ff, sfx_cfg_in;

   // String state.
   slot_type           win_ff [MAX_GRAM_CHARS];
   slot_type           win_in [MAX_GRAM_CHARS];
   logic [LEN_W-1:0]   len_ff [MAX_GRAM_CHARS];
   logic [LEN_W-1:0]   len_in [MAX_GRAM_CHARS];
   logic [FILL_W-1:0]  fill_ff, fill_in;
   slot_type           pend_ff, pend_in, pend_new;
   logic [LEN_W-1:0]   pcnt_ff, pcnt_in;
   logic [LEN_W-1:0]   elen_ff, elen_in;
   logic               gdone_ff, gdone_in;
   logic               halt_ff, halt_in;

   // Read-out plan and counters.
   logic               sfx_ff, sfx_in;
   logic               sts_ff, sts_in;
   logic [CIDX_W-1:0]  ci_ff, ci_in;
   logic [BIDX_W-1:0]  bj_ff, bj_in;

   // Output register.
   logic               ov_ff, ov_in;
   logic               kind_ff, kind_in;
   logic [BYTE_W-1:0]  obyte_ff, obyte_in;
   logic               gend_ff, gend_in;
   logic               any_ff, any_in;
   logic               last_ff, last_in;

   // Decode terms.
   logic [GSIZE_W-1:0] n_eff;
   logic [LEN_W-1:0]   lead_len;
   logic [BYTE_W-1:0]  lo, hi;
   logic               dec_ok;
   logic [LEN_W-1:0]   new_cnt;
   logic [LEN_W-1:0]   new_elen;
   logic               complete;
   logic [FILL_W-1:0]  fill_new;
   logic               gram_go;
   logic               status_go;
   logic [LEN_W-1:0]   len_m1;
   logic               byte_last;
   logic               out_free;

   always_comb begin
      n_eff = (gsize_ff > GSIZE_W'(MAX_GRAM_CHARS)) ? GSIZE_W'(MAX_GRAM_CHARS) : gsize_ff;

      if (in_byte == 8'h00) begin
         lead_len = 3'd0;
      end else if (in_byte < 8'h80) begin
         lead_len = 3'd1;
      end else if (in_byte >= 8'hC2 && in_byte <= 8'hDF) begin
         lead_len = 3'd2;
      end else if (in_byte >= 8'hE0 && in_byte <= 8'hEF) begin
         lead_len = 3'd3;
      end else if (in_byte >= 8'hF0 && in_byte <= 8'hF4) begin
         lead_len = 3'd4;
      end else begin
         lead_len = 3'd0;
      end

      lo = 8'h80;
      hi = 8'hBF;
      if (pcnt_ff == 3'd1) begin
         if (pend_ff[0] == 8'hE0) begin
            lo = 8'hA0;
         end else if (pend_ff[0] == 8'hED) begin
            hi = 8'h9F;
         end else if (pend_ff[0] == 8'hF0) begin
            lo = 8'h90;
         end else if (pend_ff[0] == 8'hF4) begin
            hi = 8'h8F;
         end
      end

      if (pcnt_ff == 3'd0) begin
         dec_ok   = (lead_len != 3'd0);
         new_elen = lead_len;
      end else begin
         dec_ok   = (in_byte >= lo) && (in_byte <= hi) && (pcnt_ff < LEN_W'(SLOT_BYTES));
         new_elen = elen_ff;
      end
      new_cnt  = pcnt_ff + 3'd1;
      complete = !halt_ff && dec_ok && (new_cnt >= new_elen);

      if (complete && (fill_ff < FILL_W'(MAX_GRAM_CHARS))) begin
         fill_new = fill_ff + FILL_W'(1);
      end else begin
         fill_new = fill_ff;
      end

      gram_go   = complete && (n_eff != '0) && (GSIZE_W'(fill_new) >= n_eff)
                  && (gdone_ff || !end_of_string);
      status_go = end_of_string && (n_eff != '0);

      pend_new = pend_ff;
      pend_new[pcnt_ff[BIDX_W-1:0]] = in_byte;

      len_m1    = len_ff[ci_ff] - LEN_W'(1);
      byte_last = (bj_ff == len_m1[BIDX_W-1:0]);
      out_free  = !ov_ff || rsp.ready;
   end

   always_comb begin
      stat.gram_go   = gram_go;
      stat.prefix_go = gdone_ff && pfx_cfg_ff;
      stat.status_go = status_go;
      stat.eos_now   = end_of_string;
      stat.suffix    = sfx_ff;
      stat.status    = sts_ff;
      stat.byte_last = byte_last;
      stat.char_last = (ci_ff == CIDX_W'(MAX_GRAM_CHARS - 1));
      stat.out_free  = out_free;
   end

   always_comb begin
      gsize_in   = gsize_ff;
      pfx_cfg_in = pfx_cfg_ff;
      sfx_cfg_in = sfx_cfg_ff;
      win_in     = win_ff;
      len_in     = len_ff;
      fill_in    = fill_ff;
      pend_in    = pend_ff;
      pcnt_in    = pcnt_ff;
      elen_in    = elen_ff;
      gdone_in   = gdone_ff;
      halt_in    = halt_ff;
      sfx_in     = sfx_ff;
      sts_in     = sts_ff;
      ci_in      = ci_ff;
      bj_in      = bj_ff;
      kind_in    = kind_ff;
      obyte_in   = obyte_ff;
      gend_in    = gend_ff;
      any_in     = any_ff;
      last_in    = last_ff;
      ov_in      = ov_ff && !rsp.ready;

      if (cmd.take && !halt_ff) begin
         if (!dec_ok) begin
            halt_in = 1'b1;
         end else begin
            pend_in = pend_new;
            if (complete) begin
               for (int k = 0; k < MAX_GRAM_CHARS - 1; k++) begin
                  win_in[k] = win_ff[k+1];
                  len_in[k] = len_ff[k+1];
               end
               win_in[MAX_GRAM_CHARS-1] = pend_new;
               len_in[MAX_GRAM_CHARS-1] = new_cnt;
               fill_in = fill_new;
               pcnt_in = '0;
               elen_in = '0;
            end else begin
               pcnt_in = new_cnt;
               elen_in = new_elen;
            end
         end
      end

      if (cmd.take) begin
         sfx_in = !end_of_string && sfx_cfg_ff;
         sts_in = status_go;
         if (gram_go) begin
            gdone_in = 1'b1;
            ci_in    = CIDX_W'(MAX_GRAM_CHARS - int'(n_eff));
            bj_in    = '0;
         end
      end

      if (cmd.emit) begin
         ov_in    = 1'b1;
         gend_in  = cmd.gram_end;
         last_in  = cmd.last;
         kind_in  = (cmd.src == SRC_STATUS);
         any_in   = (cmd.src == SRC_STATUS) && gdone_ff;
         case (cmd.src)
            SRC_MARK:   obyte_in = MARK_BYTE;
            SRC_WINDOW: obyte_in = win_ff[ci_ff][bj_ff];
            SRC_STATUS: obyte_in = '0;
            default:    obyte_in = '0;
         endcase
         if (cmd.src == SRC_WINDOW) begin
            if (byte_last) begin
               bj_in = '0;
               ci_in = ci_ff + CIDX_W'(1);
            end else begin
               bj_in = bj_ff + BIDX_W'(1);
            end
         end
      end

      if (cmd.clear) begin
         for (int k = 0; k < MAX_GRAM_CHARS; k++) begin
            len_in[k] = '0;
         end
         fill_in  = '0;
         pcnt_in  = '0;
         elen_in  = '0;
         gdone_in = 1'b0;
         halt_in  = 1'b0;
      end

      if (csr_we) begin
         case (csr_index)
            CSR_GRAM_SIZE:  gsize_in   = csr_wdata;
            CSR_ADD_PREFIX: pfx_cfg_in = csr_wdata[0];
            CSR_ADD_SUFFIX: sfx_cfg_in = csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         gsize_ff   <= GRAM_SIZE_RST;
         pfx_cfg_ff <= 1'b0;
         sfx_cfg_ff <= 1'b0;
         for (int k = 0; k < MAX_GRAM_CHARS; k++) begin
            len_ff[k] <= '0;
         end
         fill_ff    <= '0;
         pcnt_ff    <= '0;
         elen_ff    <= '0;
         gdone_ff   <= 1'b0;
         halt_ff    <= 1'b0;
         ov_ff      <= 1'b0;
      end else begin
         gsize_ff   <= gsize_in;
         pfx_cfg_ff <= pfx_cfg_in;
         sfx_cfg_ff <= sfx_cfg_in;
         len_ff     <= len_in;
         fill_ff    <= fill_in;
         pcnt_ff    <= pcnt_in;
         elen_ff    <= elen_in;
         gdone_ff   <= gdone_in;
         halt_ff    <= halt_in;
         ov_ff      <= ov_in;
      end
   end

   // Payload and plan registers.
   always_ff @(posedge clock) begin
      win_ff   <= win_in;
      pend_ff  <= pend_in;
      sfx_ff   <= sfx_in;
      sts_ff   <= sts_in;
      ci_ff    <= ci_in;
      bj_ff    <= bj_in;
      kind_ff  <= kind_in;
      obyte_ff <= obyte_in;
      gend_ff  <= gend_in;
      any_ff   <= any_in;
      last_ff  <= last_in;
   end

   assign rsp.valid     = ov_ff;
   assign rsp.kind      = kind_ff;
   assign rsp.out_byte  = obyte_ff;
   assign rsp.gram_end  = gend_ff;
   assign rsp.any_grams = any_ff;
   assign rsp.last      = last_ff;

   `UCNG_NEVER(a_fill_bound, clock, reset, fill_ff > FILL_W'(MAX_GRAM_CHARS))
   `UCNG_NEVER(a_status_is_last, clock, reset, ov_ff && kind_ff && !last_ff)

endmodule

`default_nettype wire

FILE: hdl/utf8_char_ngram_extractor_top.sv
// ----------------------------------------------------------------------------
// UTF-8 character n-gram extractor
// Decodes UTF-8 bytes, keeps the last eight characters and emits character
// n-grams byte by byte and, for gram size > 0, one status item per string.
// ----------------------------------------------------------------------------
// Flow: a byte is taken only in the idle state. Its prefix, gram, suffix and
// status items then enter the output register from the matching states,
// one result item per cycle while the receiver is ready; the next byte is
// taken once all of them have been handed to that single output register.
// Reset: synchronous, active high; clears control state and loads register
// defaults at once, with no clearing pass over the character window.
`default_nettype none

module utf8_char_ngram_extractor_top (
   input  wire                                clock,
   input  wire                                reset,
   ucng_req_if.sink                           req,
   ucng_rsp_if.source                         rsp,
   input  wire                                csr_we,
   input  wire  [ucng_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire  [ucng_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import ucng_pkg::*;

   // The controller and the datapath talk only through these two bundles.
   ucng_cmd_type  cmd;
   ucng_stat_type stat;
   logic          req_ready;

   // The controller owns the input handshake. It takes a byte only when it
   // is idle, i.e. once every item of the previous byte has been handed to
   // the output register; an item still waiting there does not hold up the
   // next byte.
   ucng_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   assign req.ready = req_ready;

   // The datapath decodes the accepted byte in the cycle it is taken, shifts
   // completed characters into the window, then walks the gram one byte per
   // cycle into the output register, which drives rsp, while it has room.
   ucng_dp u_dp (
      .clock         (clock),
      .reset         (reset),
      .in_byte       (req.in_byte),
      .end_of_string (req.end_of_string),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .cmd           (cmd),
      .stat          (stat),
      .rsp           (rsp)
   );

endmodule

`default_nettype wire

FILE: tb/sv/tb_utf8_char_ngram_extractor_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-8 character n-gram extractor testbench
// Feeds strings byte by byte through the request channel and checks every
// result item against an in-bench model of the decoder, the character window
// and the gram framing. A short directed table covers the register extremes
// and the error cases, then random strings run under bursty traffic, random
// back-pressure and one long output stall.
// ----------------------------------------------------------------------------

module tb_utf8_char_ngram_extractor_top;

   // Clock period, reset length and the margins used when the block is idle.
   localparam int  HALF_PERIOD_NS  = 5;
   localparam int  RESET_CYCLES    = 12;
   localparam int  IDLE_SETTLE     = 4;
   localparam int  END_SETTLE      = 16;
   localparam int  RSP_HOLD_CYCLES = 400;
   localparam int  PRESSURE_ITEMS  = 48;
   localparam int  RANDOM_ITEMS    = 235;
   localparam int  REPORT_LIMIT    = 10;
   localparam time TIMEOUT_NS      = 5_000_000;

   localparam int CHARS      = ucng_pkg::MAX_GRAM_CHARS;
   localparam int SLOT       = ucng_pkg::SLOT_BYTES;
   localparam int WIN_BYTES  = CHARS * SLOT;

   // The kind field of a result item.
   localparam logic KIND_GRAM   = 1'b0;
   localparam logic KIND_STATUS = 1'b1;

   // How a row of the directed table is applied and checked. Byte rows go
   // through the model; quiet and status rows carry their expectation with
   // them; settings rows program the registers once the block is idle.
   typedef enum logic [1:0] {
      ROW_BYTE,
      ROW_QUIET,
      ROW_STATUS,
      ROW_SETTINGS
   } row_op_type;

   // Receiver pacing modes.
   typedef enum logic [1:0] {
      PACE_OPEN,
      PACE_COIN,
      PACE_SPARSE,
      PACE_RHYTHM
   } pace_type;

   typedef struct packed {
      logic       kind;
      logic [7:0] out_byte;
      logic       gram_end;
      logic       any_grams;
      logic       last;
   } gram_item_type;

   typedef struct packed {
      row_op_type op;
      logic [7:0] in_byte;
      logic       eos;
      logic       any;
      logic [3:0] gsize;
      logic       prefix;
      logic       suffix;
   } stim_row_type;

   // The directed table. Fields: operation, byte, end of string, expected
   // any_grams flag (status rows), then gram size, prefix and suffix
   // (settings rows).
   localparam int DIRECTED_COUNT = 29;
   localparam stim_row_type DIRECTED_ROWS [DIRECTED_COUNT] = '{
      // Register defaults after reset: grams of three, no markers. A string
      // of one character is too short for a gram.
      '{ROW_STATUS,   8'h61, 1'b1, 1'b0, 4'd0,  1'b0, 1'b0},
      // A NUL byte stops extraction at once.
      '{ROW_STATUS,   8'h00, 1'b1, 1'b0, 4'd0,  1'b0, 1'b0},
      // A string of exactly three characters yields no gram at all.
      '{ROW_QUIET,    8'h61, 1'b0, 1'b0, 4'd0,  1'b0, 1'b0},
      '{ROW_QUIET,    8'h62, 1'b0, 1'b0, 4'd0,  1'b0, 1'b0},
      '{ROW_STATUS,   8'h63, 1'b1, 1'b0, 4'd0,  1'b0, 1'b0},
      // Smallest gram with both markers on.
      '{ROW_SETTINGS, 8'h00, 1'b0, 1'b0, 4'd1,  1'b1, 1'b1},
      // The highest code point, then a final ASCII character.
      '{ROW_BYTE,     8'hF4, 1'b0, 1'b0, 4'd0,  1'b0, 1'b0},
      '{ROW_BYTE,     8'h8F, 1'b0, 1'b0, 4'd0,  1'b0, 1'b0},
      '{ROW_BYTE,     8'hBF, 1'b0, 1'b0, 4'd0,  1'b0, 1'b0},
      '{ROW_BYTE,     8'hBF, 1'b0, 1'b0, 4'd0,  1'b0, 1'b0},
      '{ROW_BYTE,     8'h7F, 1'b1, 1'b0, 4'd0,  1'b0, 1'b0},
      // An overlong three-byte form: E0 must be followed by A0 or more.
      '{ROW_QUIET,    8'hE0, 1'b0, 1'b0, 4'd0,  1'b0, 1'b0},
      '{ROW_STATUS,   8'h9F, 1'b1, 1'b0, 4'd0,  1'b0, 1'b0},
      // A byte that can never start a character.
      '{ROW_STATUS,   8'hFF, 1'b1, 1'b0, 4'd0,  1'b0, 1'b0},
      // An oversized gram size acts as eight; a truncated character is lost.
      '{ROW_SETTINGS, 8'h00, 1'b0, 1'b0, 4'd15, 1'b0, 1'b1},
      '{ROW_QUIET,    8'h41, 1'b0, 1'b0, 4'd0,  1'b0, 1'b0},
      '{ROW_STATUS,   8'hE2, 1'b1, 1'b0, 4'd0,  1'b0, 1'b0},
      // A gram size of zero silences the block, status included.
      '{ROW_SETTINGS, 8'h00, 1'b0, 1'b0, 4'd0,  1'b1, 1'b0},
      '{ROW_QUIET,    8'h41, 1'b0, 1'b0, 4'd0,  1'b0, 1'b0},
      '{ROW_QUIET,    8'h42, 1'b1, 1'b0, 4'd0,  1'b0, 1'b0},
      // Bigrams over mixed lengths, ending on an underscore character.
      '{ROW_SETTINGS, 8'h00, 1'b0, 1'b0, 4'd2,  1'b0, 1'b0},
      '{ROW_BYTE,     8'hED, 1'b0, 1'b0, 4'd0,  1'b0, 1'b0},
      '{ROW_BYTE,     8'h9F, 1'b0, 1'b0, 4'd0,  1'b0, 1'b0},
      '{ROW_BYTE,     8'hBF, 1'b0, 1'b0, 4'd0,  1'b0, 1'b0},
      '{ROW_BYTE,     8'hF0, 1'b0, 1'b0, 4'd0,  1'b0, 1'b0},
      '{ROW_BYTE,     8'h90, 1'b0, 1'b0, 4'd0,  1'b0, 1'b0},
      '{ROW_BYTE,     8'h80, 1'b0, 1'b0, 4'd0,  1'b0, 1'b0},
      '{ROW_BYTE,     8'h80, 1'b0, 1'b0, 4'd0,  1'b0, 1'b0},
      '{ROW_BYTE,     8'h5F, 1'b1, 1'b0, 4'd0,  1'b0, 1'b0}
   };

   logic clock;
   logic reset;
   logic csr_we;
   logic [ucng_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [ucng_pkg::CSR_DATA_W-1:0] csr_wdata;

   ucng_req_if req_bus ();
   ucng_rsp_if rsp_bus ();

   utf8_char_ngram_extractor_top dut (
      .clock     (clock),
      .reset     (reset),
      .req       (req_bus.sink),
      .rsp       (rsp_bus.source),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // The kind of item on offer travels alongside the request, so that the
   // checker sees the row that belongs to the byte being accepted.
   row_op_type offer_op;
   logic       offer_any;

   // Model of the extractor: register copies and the per-string state.
   logic [3:0] cfg_gram_size;
   logic       cfg_prefix;
   logic       cfg_suffix;

   logic [7:0]  win_bytes  [WIN_BYTES];
   logic [2:0]  char_bytes [CHARS];
   int unsigned chars_kept;
   logic [7:0]  partial    [SLOT];
   int unsigned partial_count;
   int unsigned partial_len;
   bit          gram_seen;
   bit          decode_halted;

   gram_item_type byte_results [$];
   gram_item_type results_due  [$];
   logic [7:0]    utf8_text    [$];

   int unsigned failures;
   int unsigned results_checked;
   int unsigned burst_left;
   int unsigned steady_left;
   int unsigned hold_requests;

   // ------------------------------------------------------------------------
   // Clock.
   // ------------------------------------------------------------------------
   initial clock = 1'b0;

   always begin
      #(HALF_PERIOD_NS) clock = 1'b1;
      #(HALF_PERIOD_NS) clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // Model of the extractor.
   // ------------------------------------------------------------------------

   // Returns the string state to its reset value, as at the end of a string.
   function automatic void forget_string();
      int unsigned i;
      for (i = 0; i < WIN_BYTES; i++) begin
         win_bytes[i] = 8'h00;
      end
      for (i = 0; i < CHARS; i++) begin
         char_bytes[i] = 3'd0;
      end
      for (i = 0; i < SLOT; i++) begin
         partial[i] = 8'h00;
      end
      chars_kept    = 0;
      partial_count = 0;
      partial_len   = 0;
      gram_seen     = 1'b0;
      decode_halted = 1'b0;
   endfunction

   // Works out the result items caused by one accepted byte and leaves them
   // in byte_results. The byte is decoded first; a completed character is
   // shifted into the window, and a full enough window yields the newest
   // gram, framed by the underscore markers that the registers ask for.
   function automatic void predict_ngrams(input logic [7:0] b, input logic eos);
      int unsigned   n;
      int unsigned   i;
      int unsigned   j;
      logic [7:0]    lo;
      logic [7:0]    hi;
      bit            completed;
      gram_item_type item;

      byte_results.delete();
      n = (cfg_gram_size > CHARS) ? CHARS : cfg_gram_size;
      completed = 1'b0;
      lo = 8'h80;
      hi = 8'hBF;

      if (!decode_halted) begin
         if (partial_count == 0) begin
            // A lead byte sets the length of the character.
            if (b == 8'h00) begin
               decode_halted = 1'b1;
            end else if (b < 8'h80) begin
               partial_len = 1;
            end else if (b >= 8'hC2 && b <= 8'hDF) begin
               partial_len = 2;
            end else if (b >= 8'hE0 && b <= 8'hEF) begin
               partial_len = 3;
            end else if (b >= 8'hF0 && b <= 8'hF4) begin
               partial_len = 4;
            end else begin
               decode_halted = 1'b1;
            end
            if (!decode_halted) begin
               partial[0]    = b;
               partial_count = 1;
            end
         end else begin
            // The second byte of some leads has a narrower range, which
            // rules out overlong forms, surrogates and code points too high.
            if (partial_count == 1) begin
               case (partial[0])
                  8'hE0: lo = 8'hA0;
                  8'hED: hi = 8'h9F;
                  8'hF0: lo = 8'h90;
                  8'hF4: hi = 8'h8F;
                  default: ;
               endcase
            end
            if (b < lo || b > hi || partial_count >= SLOT) begin
               decode_halted = 1'b1;
            end else begin
               partial[partial_count] = b;
               partial_count++;
            end
         end

         if (!decode_halted && partial_count == partial_len) begin
            for (i = 0; i < WIN_BYTES - SLOT; i++) begin
               win_bytes[i] = win_bytes[i + SLOT];
            end
            for (i = 0; i < SLOT; i++) begin
               win_bytes[WIN_BYTES - SLOT + i] = partial[i];
            end
            for (i = 0; i < CHARS - 1; i++) begin
               char_bytes[i] = char_bytes[i + 1];
            end
            char_bytes[CHARS - 1] = 3'(partial_count);
            if (chars_kept < CHARS) begin
               chars_kept++;
            end
            partial_count = 0;
            partial_len   = 0;
            completed     = 1'b1;
         end
      end

      // The first gram of a string is held back when the final byte would
      // complete it, so a string of exactly n characters gives none.
      if (completed && n > 0 && chars_kept >= n && (gram_seen || !eos)) begin
         item = '{KIND_GRAM, ucng_pkg::MARK_BYTE, 1'b0, 1'b0, 1'b0};
         if (gram_seen && cfg_prefix) begin
            byte_results.push_back(item);
         end
         for (i = CHARS - n; i < CHARS; i++) begin
            for (j = 0; j < char_bytes[i]; j++) begin
               item.out_byte = win_bytes[i * SLOT + j];
               byte_results.push_back(item);
            end
         end
         if (!eos && cfg_suffix) begin
            item.out_byte = ucng_pkg::MARK_BYTE;
            byte_results.push_back(item);
         end
         byte_results[byte_results.size() - 1].gram_end = 1'b1;
         gram_seen = 1'b1;
      end

      if (eos) begin
         if (n > 0) begin
            byte_results.push_back('{KIND_STATUS, 8'h00, 1'b0, gram_seen, 1'b0});
         end
         forget_string();
      end

      if (byte_results.size() > 0) begin
         byte_results[byte_results.size() - 1].last = 1'b1;
      end
   endfunction

   // ------------------------------------------------------------------------
   // Checking.
   // ------------------------------------------------------------------------
   function automatic void note_failure(input string what);
      if (failures < REPORT_LIMIT) begin
         $display("[%0t] ERROR: %s", $realtime, what);
      end
      failures++;
   endfunction

   // Both channels are sampled at the rising edge, before anything driven at
   // that edge takes effect. An accepted byte is run through the model and
   // its expectations queued; an accepted result is compared with the
   // oldest expectation.
   always @(posedge clock) begin : result_check
      gram_item_type got;
      gram_item_type want;

      if (!reset) begin
         if (req_bus.valid && req_bus.ready) begin
            predict_ngrams(req_bus.in_byte, req_bus.end_of_string);
            case (offer_op)
               ROW_QUIET: ;
               ROW_STATUS: begin
                  results_due.push_back('{KIND_STATUS, 8'h00, 1'b0, offer_any, 1'b1});
               end
               default: begin
                  foreach (byte_results[k]) begin
                     results_due.push_back(byte_results[k]);
                  end
               end
            endcase
         end

         if (rsp_bus.valid && rsp_bus.ready) begin
            got = '{rsp_bus.kind, rsp_bus.out_byte, rsp_bus.gram_end,
                    rsp_bus.any_grams, rsp_bus.last};
            if (results_due.size() == 0) begin
               note_failure($sformatf({"unexpected result item kind=%0d byte=%02h ",
                  "gram_end=%0d any=%0d last=%0d"}, got.kind, got.out_byte,
                  got.gram_end, got.any_grams, got.last));
            end else begin
               want = results_due.pop_front();
               if (got !== want) begin
                  note_failure($sformatf({"result item %0d: expected kind=%0d ",
                     "byte=%02h gram_end=%0d any=%0d last=%0d, got kind=%0d ",
                     "byte=%02h gram_end=%0d any=%0d last=%0d"}, results_checked,
                     want.kind, want.out_byte, want.gram_end, want.any_grams,
                     want.last, got.kind, got.out_byte, got.gram_end,
                     got.any_grams, got.last));
               end
            end
            results_checked++;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Receiver. It changes its pacing every so often: always ready, a coin
   // toss, mostly stalled, or a fixed rhythm. When the stimulus asks for it,
   // it holds ready low for a long stretch so that the block backs up.
   // ------------------------------------------------------------------------
   initial begin : rsp_pacing
      pace_type    mode;
      int unsigned mode_left;
      int unsigned holds_done;
      int unsigned tick;

      mode       = PACE_OPEN;
      mode_left  = 0;
      holds_done = 0;
      tick       = 0;
      rsp_bus.ready = 1'b0;

      forever begin
         @(posedge clock);
         if (holds_done != hold_requests) begin
            holds_done = hold_requests;
            rsp_bus.ready <= 1'b0;
            repeat (RSP_HOLD_CYCLES) @(posedge clock);
         end else begin
            if (mode_left == 0) begin
               mode      = pace_type'($urandom_range(0, 3));
               mode_left = $urandom_range(16, 160);
            end else begin
               mode_left--;
            end
            case (mode)
               PACE_OPEN:   rsp_bus.ready <= 1'b1;
               PACE_COIN:   rsp_bus.ready <= 1'($urandom_range(0, 1));
               PACE_SPARSE: rsp_bus.ready <= ($urandom_range(0, 4) == 0);
               default:     rsp_bus.ready <= ((tick % 5) < 3);
            endcase
            tick++;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Sender helpers.
   // ------------------------------------------------------------------------

   // Offers one byte and waits until it is taken. Bytes go out in bursts of
   // random length; at the end of a burst the request is dropped for a random
   // gap. While steady_left is non-zero no gap is inserted at all.
   task automatic offer_byte(input logic [7:0] b, input logic eos,
                             input row_op_type op, input logic any);
      req_bus.valid         <= 1'b1;
      req_bus.in_byte       <= b;
      req_bus.end_of_string <= eos;
      offer_op              <= op;
      offer_any             <= any;
      do @(posedge clock); while (!req_bus.ready);

      if (steady_left > 0) begin
         steady_left--;
      end else if (burst_left > 0) begin
         burst_left--;
      end else begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
         burst_left = $urandom_range(0, 24);
      end
   endtask

   // Stops offering and waits until every expected item has come back, then
   // lets the block settle in case the last byte is still being worked on.
   task automatic wait_until_idle();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (results_due.size() != 0);
      repeat (IDLE_SETTLE) @(posedge clock);
   endtask

   // Writes all three registers in turn. The block is idle, so
   // the model may take the new values straight away.
   task automatic apply_settings(input logic [3:0] gsize, input logic prefix,
                                 input logic suffix);
      csr_we    <= 1'b1;
      csr_index <= ucng_pkg::CSR_GRAM_SIZE;
      csr_wdata <= gsize;
      @(posedge clock);
      csr_index <= ucng_pkg::CSR_ADD_PREFIX;
      csr_wdata <= ucng_pkg::CSR_DATA_W'(prefix);
      @(posedge clock);
      csr_index <= ucng_pkg::CSR_ADD_SUFFIX;
      csr_wdata <= ucng_pkg::CSR_DATA_W'(suffix);
      @(posedge clock);
      csr_we <= 1'b0;
      cfg_gram_size = gsize;
      cfg_prefix    = prefix;
      cfg_suffix    = suffix;
   endtask

   // Builds one random string in utf8_text. Most strings are well-formed
   // UTF-8 of one to ten characters of every length; the rest are raw noise,
   // a well-formed string with one byte overwritten, or one cut short.
   function automatic void compose_text();
      int unsigned flavour;
      int unsigned nchars;
      int unsigned c;
      int unsigned k;
      int unsigned len;
      logic [7:0]  lead;
      logic [7:0]  lo;
      logic [7:0]  hi;

      utf8_text.delete();
      flavour = $urandom_range(0, 9);
      if (flavour == 0) begin
         repeat ($urandom_range(1, 6)) utf8_text.push_back(8'($urandom_range(0, 255)));
      end else begin
         nchars = $urandom_range(1, 10);
         for (c = 0; c < nchars; c++) begin
            len = $urandom_range(1, 4);
            lo  = 8'h80;
            hi  = 8'hBF;
            case (len)
               1:       lead = 8'($urandom_range(8'h01, 8'h7F));
               2:       lead = 8'($urandom_range(8'hC2, 8'hDF));
               3:       lead = 8'($urandom_range(8'hE0, 8'hEF));
               default: lead = 8'($urandom_range(8'hF0, 8'hF4));
            endcase
            case (lead)
               8'hE0: lo = 8'hA0;
               8'hED: hi = 8'h9F;
               8'hF0: lo = 8'h90;
               8'hF4: hi = 8'h8F;
               default: ;
            endcase
            utf8_text.push_back(lead);
            if (len > 1) begin
               utf8_text.push_back(8'($urandom_range(lo, hi)));
            end
            for (k = 2; k < len; k++) begin
               utf8_text.push_back(8'($urandom_range(8'h80, 8'hBF)));
            end
         end
         if (flavour == 1) begin
            utf8_text[$urandom_range(0, utf8_text.size() - 1)] = 8'($urandom_range(0, 255));
         end else if (flavour == 2 && utf8_text.size() > 1) begin
            void'(utf8_text.pop_back());
         end
      end
   endfunction

   // ------------------------------------------------------------------------
   // Stimulus.
   // ------------------------------------------------------------------------
   initial begin : stimulus
      stim_row_type row;
      int unsigned  r;
      int unsigned  i;
      int unsigned  random_sent;
      int unsigned  phase_left;
      int unsigned  phase_no;
      logic [3:0]   gsize;

      // Every input of the block starts at a known value.
      reset                 = 1'b1;
      csr_we                = 1'b0;
      csr_index             = ucng_pkg::CSR_GRAM_SIZE;
      csr_wdata             = '0;
      req_bus.valid         = 1'b0;
      req_bus.in_byte       = 8'h00;
      req_bus.end_of_string = 1'b0;
      offer_op              = ROW_BYTE;
      offer_any             = 1'b0;

      failures        = 0;
      results_checked = 0;
      burst_left      = 0;
      steady_left     = 0;
      hold_requests   = 0;
      random_sent     = 0;
      phase_no        = 0;

      // The model starts from the register defaults and an empty string.
      cfg_gram_size = ucng_pkg::GRAM_SIZE_RST;
      cfg_prefix    = 1'b0;
      cfg_suffix    = 1'b0;
      forget_string();

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part: the table is walked in order. Settings rows wait for
      // the block to drain before touching the registers.
      for (r = 0; r < DIRECTED_COUNT; r++) begin
         row = DIRECTED_ROWS[r];
         if (row.op == ROW_SETTINGS) begin
            wait_until_idle();
            apply_settings(row.gsize, row.prefix, row.suffix);
         end else begin
            offer_byte(row.in_byte, row.eos, row.op, row.any);
         end
      end

      // The first random phase runs bigrams with both markers while the
      // receiver stalls for a long stretch. The sender keeps offering with
      // no gaps, so the block fills and has to hold off its input.
      wait_until_idle();
      apply_settings(4'd2, 1'b1, 1'b1);
      hold_requests++;
      steady_left = PRESSURE_ITEMS;
      phase_left  = 6;

      while (random_sent < RANDOM_ITEMS) begin
         if (phase_left == 0) begin
            // The registers change only between phases, once all results of
            // the previous phase are in. The first change goes to the full
            // window; later ones lean towards small grams with the odd
            // disabled or oversized setting.
            wait_until_idle();
            phase_no++;
            if (phase_no == 1) begin
               gsize = 4'd8;
            end else begin
               case ($urandom_range(0, 7))
                  0:       gsize = 4'd0;
                  1:       gsize = 4'd8;
                  2:       gsize = 4'($urandom_range(9, 15));
                  default: gsize = 4'($urandom_range(1, 4));
               endcase
            end
            apply_settings(gsize, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            phase_left = $urandom_range(2, 6);
         end

         compose_text();
         for (i = 0; i < utf8_text.size(); i++) begin
            offer_byte(utf8_text[i], (i == utf8_text.size() - 1), ROW_BYTE, 1'b0);
         end
         random_sent += utf8_text.size();
         phase_left--;
      end

      wait_until_idle();
      repeat (END_SETTLE) @(posedge clock);

      if (failures == 0 && results_due.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   // Guards against a hang, for instance a result item that never comes.
   initial begin : watchdog
      #(TIMEOUT_NS);
      $display("Regression FAIL");
      $finish;
   end

endmodule
